FILE: rtl/u8cp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the UTF-8 to codepage decoder.
// Used by every file in the rtl folder; depends on nothing else.

package u8cp_pkg;

   // Input item commands.
   localparam logic CMD_TEXT        = 1'b0;
   localparam logic CMD_TABLE_WRITE = 1'b1;

   // Sizes.
   localparam int TABLE_DEPTH     = 65536;
   localparam int WIN_BYTES       = 3;
   localparam int MAX_RESULTS     = 3;
   localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int RSP_QUEUE_DEPTH = 8;
   localparam int THRESHOLD_W     = 9;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 9'd161;

   // Byte-order mark and lead byte decoding constants.
   localparam logic [7:0] BOM_BYTE0      = 8'hef;
   localparam logic [7:0] BOM_BYTE1      = 8'hbb;
   localparam logic [7:0] BOM_BYTE2      = 8'hbf;
   localparam logic [7:0] LEAD3_MASK     = 8'he0;
   localparam logic [7:0] LEAD3_DATA     = 8'h0f;
   localparam logic [7:0] CONT_DATA      = 8'h3f;
   localparam logic [7:0] MULTI_BYTE_BIT = 8'h80;

   typedef struct packed {
      logic        command;
      logic [7:0]  text_byte;
      logic        end_flag;
      logic [15:0] table_index;
      logic [7:0]  table_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       is_last;
   } rsp_type;

   // Lookahead bytes still undecided, plus string position flags.
   typedef struct packed {
      logic [1:0][7:0] win;
      logic [1:0]      cnt;
      logic            at_start;
      logic            stopped;
   } str_state_type;

   localparam str_state_type STR_STATE_RESET = '{
      win: '0, cnt: 2'd0, at_start: 1'b1, stopped: 1'b0
   };

   typedef struct packed {
      logic [RES_CNT_W-1:0]          count;
      rsp_type [MAX_RESULTS-1:0]     results;
      str_state_type                 next_state;
   } decide_type;

endpackage

FILE: rtl/u8cp_decide.sv
`timescale 1ns / 1ps
// Decision logic for one text byte: drains the lookahead window and builds results.
// Depends on u8cp_pkg.

module u8cp_decide (
   input  u8cp_pkg::str_state_type            state_in,
   input  logic [7:0]                         text_byte,
   input  logic                               end_flag,
   input  logic [7:0]                         entry_head0,
   input  logic [7:0]                         entry_head1,
   input  logic [u8cp_pkg::THRESHOLD_W-1:0]   accept_threshold,
   input  logic                               accept_enable,
   output u8cp_pkg::decide_type               decide_out
);

   logic [2:0][7:0]                          win_v;
   logic [1:0]                               n_v;
   logic [1:0]                               h_v;
   logic                                     ast_v;
   logic                                     stp_v;
   logic                                     done_v;
   logic [u8cp_pkg::RES_CNT_W-1:0]           nres_v;
   u8cp_pkg::rsp_type [u8cp_pkg::MAX_RESULTS-1:0] res_v;
   u8cp_pkg::str_state_type                  next_v;
   logic [7:0]                               c_v;
   logic [2:0]                               pos1_v;
   logic [2:0]                               pos2_v;
   logic                                     in1_v;
   logic                                     in2_v;
   logic                                     known1_v;
   logic                                     known2_v;
   logic [7:0]                               v1_v;
   logic [7:0]                               v2_v;
   logic                                     hold_v;
   logic                                     bom_v;
   logic                                     undec_v;
   logic [1:0]                               size_v;
   logic [7:0]                               entry_v;
   logic                                     acc_v;

   always_comb begin
      // Window is the held bytes followed by the new byte, unless output already stopped.
      win_v[0] = (state_in.cnt != 2'd0) ? state_in.win[0] : text_byte;
      win_v[1] = (state_in.cnt == 2'd2) ? state_in.win[1] :
                 (state_in.cnt == 2'd1) ? text_byte : 8'h00;
      win_v[2] = (state_in.cnt == 2'd2) ? text_byte : 8'h00;
      n_v      = state_in.stopped ? 2'd0 : 2'(state_in.cnt + 2'd1);
      h_v      = 2'd0;
      ast_v    = state_in.at_start;
      stp_v    = state_in.stopped;
      done_v   = 1'b0;
      nres_v   = '0;
      res_v    = '0;
      c_v      = 8'h00;
      pos1_v   = 3'd0;
      pos2_v   = 3'd0;
      in1_v    = 1'b0;
      in2_v    = 1'b0;
      known1_v = 1'b0;
      known2_v = 1'b0;
      v1_v     = 8'h00;
      v2_v     = 8'h00;
      hold_v   = 1'b0;
      bom_v    = 1'b0;
      undec_v  = 1'b0;
      size_v   = 2'd0;
      entry_v  = 8'h00;
      acc_v    = 1'b0;

      // Each pass decides one head; the window holds at most three bytes.
      for (int it = 0; it < u8cp_pkg::WIN_BYTES; it++) begin
         if (!done_v && !stp_v && (h_v < n_v)) begin
            c_v      = win_v[h_v];
            pos1_v   = {1'b0, h_v} + 3'd1;
            pos2_v   = {1'b0, h_v} + 3'd2;
            in1_v    = pos1_v < {1'b0, n_v};
            in2_v    = pos2_v < {1'b0, n_v};
            known1_v = in1_v | end_flag;
            known2_v = in2_v | end_flag;
            v1_v     = in1_v ? win_v[pos1_v[1:0]] : 8'h00;
            v2_v     = in2_v ? win_v[pos2_v[1:0]] : 8'h00;
            hold_v   = 1'b0;
            bom_v    = 1'b0;
            undec_v  = 1'b0;
            size_v   = 2'd0;

            if (ast_v && (c_v == u8cp_pkg::BOM_BYTE0)) begin
               if (!known1_v) begin
                  hold_v = 1'b1;
               end else if (v1_v == u8cp_pkg::BOM_BYTE1) begin
                  if (!known2_v) begin
                     hold_v = 1'b1;
                  end else if (v2_v == u8cp_pkg::BOM_BYTE2) begin
                     bom_v = 1'b1;
                  end
               end
            end

            if (hold_v) begin
               done_v = 1'b1;
            end else if (bom_v) begin
               h_v   = 2'd3;
               ast_v = 1'b0;
            end else if (c_v == 8'h00) begin
               stp_v  = 1'b1;
               done_v = 1'b1;
            end else begin
               if ((c_v & u8cp_pkg::MULTI_BYTE_BIT) != 8'h00) begin
                  if (!known1_v) begin
                     undec_v = 1'b1;
                  end else if ((c_v & u8cp_pkg::LEAD3_MASK) == u8cp_pkg::LEAD3_MASK) begin
                     if (v1_v != 8'h00) begin
                        if (!known2_v) begin
                           undec_v = 1'b1;
                        end else if (v2_v != 8'h00) begin
                           size_v = 2'd3;
                        end
                     end
                  end else if (v1_v != 8'h00) begin
                     size_v = 2'd2;
                  end
               end

               if (undec_v) begin
                  done_v = 1'b1;
               end else begin
                  // A complete sequence always ends at the newest byte, so only
                  // heads at positions zero and one ever need a table entry.
                  entry_v = (h_v == 2'd0) ? entry_head0 : entry_head1;
                  acc_v   = accept_enable && (size_v != 2'd0) &&
                            ({1'b0, entry_v} >= accept_threshold);
                  res_v[nres_v].out_char = acc_v ? entry_v : c_v;
                  res_v[nres_v].has_char = 1'b1;
                  res_v[nres_v].is_last  = 1'b0;
                  nres_v = u8cp_pkg::RES_CNT_W'(nres_v + 1'b1);
                  h_v    = 2'(h_v + (acc_v ? size_v : 2'd1));
                  ast_v  = 1'b0;
               end
            end
         end
      end

      next_v.win[0]   = (!stp_v && (h_v < n_v)) ? win_v[h_v] : 8'h00;
      pos1_v          = {1'b0, h_v} + 3'd1;
      next_v.win[1]   = (!stp_v && (pos1_v < {1'b0, n_v})) ? win_v[pos1_v[1:0]] : 8'h00;
      next_v.cnt      = stp_v ? 2'd0 : 2'(n_v - h_v);
      next_v.at_start = ast_v;
      next_v.stopped  = stp_v;

      if (end_flag) begin
         // The string closes: flag the final result, or send an empty closing result.
         if (nres_v == '0) begin
            res_v[0].out_char = 8'h00;
            res_v[0].has_char = 1'b0;
            res_v[0].is_last  = 1'b1;
            nres_v            = u8cp_pkg::RES_CNT_W'(1);
         end else begin
            res_v[u8cp_pkg::RES_CNT_W'(nres_v - 1'b1)].is_last = 1'b1;
         end
         next_v = u8cp_pkg::STR_STATE_RESET;
      end

      decide_out.count      = nres_v;
      decide_out.results    = res_v;
      decide_out.next_state = next_v;
   end

endmodule

FILE: rtl/u8cp_rsp_queue.sv
`timescale 1ns / 1ps
// Result queue: takes up to three results per cycle and hands out one per transfer.
// Depends on u8cp_pkg.

module u8cp_rsp_queue #(
   parameter int DEPTH = u8cp_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic [u8cp_pkg::RES_CNT_W-1:0]               push_count,
   input  u8cp_pkg::rsp_type [u8cp_pkg::MAX_RESULTS-1:0] push_items,
   output logic                                         room,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output u8cp_pkg::rsp_type                            rsp_payload
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u8cp_pkg::rsp_type                       queue_ff [DEPTH];
   logic [PTR_W-1:0]                        wr_ptr_ff;
   logic [PTR_W-1:0]                        wr_ptr_in;
   logic [PTR_W-1:0]                        rd_ptr_ff;
   logic [PTR_W-1:0]                        rd_ptr_in;
   logic [CNT_W-1:0]                        count_ff;
   logic [CNT_W-1:0]                        count_in;
   logic [PTR_W:0]                          wr_sum;
   logic [PTR_W:0]                          slot_sum [u8cp_pkg::MAX_RESULTS];
   logic [PTR_W-1:0]                        slot_idx [u8cp_pkg::MAX_RESULTS];
   logic                                    pop;

   assign pop         = rsp_valid & ~rsp_stall;
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = queue_ff[rd_ptr_ff];
   assign room        = count_ff <= CNT_W'(DEPTH - u8cp_pkg::MAX_RESULTS);

   always_comb begin
      for (int k = 0; k < u8cp_pkg::MAX_RESULTS; k++) begin
         slot_sum[k] = {1'b0, wr_ptr_ff} + (PTR_W + 1)'(k);
         slot_idx[k] = (slot_sum[k] >= (PTR_W + 1)'(DEPTH)) ?
                       PTR_W'(slot_sum[k] - (PTR_W + 1)'(DEPTH)) : PTR_W'(slot_sum[k]);
      end
      wr_sum    = {1'b0, wr_ptr_ff} + (PTR_W + 1)'(push_count);
      wr_ptr_in = (wr_sum >= (PTR_W + 1)'(DEPTH)) ?
                  PTR_W'(wr_sum - (PTR_W + 1)'(DEPTH)) : PTR_W'(wr_sum);
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      count_in = CNT_W'(count_ff + CNT_W'(push_count) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < u8cp_pkg::MAX_RESULTS; k++) begin
         if (u8cp_pkg::RES_CNT_W'(k) < push_count) begin
            queue_ff[slot_idx[k]] <= push_items[k];
         end
      end
   end

endmodule

FILE: rtl/utf8_to_codepage_decoder_unit.sv
`timescale 1ns / 1ps
// UTF-8 to single-byte codepage decoder, top level. Uses u8cp_pkg, u8cp_decide, u8cp_rsp_queue.
// Throughput: one input transfer per cycle while the result queue has room for three results;
// results leave at one per cycle while rsp_stall is low, and each byte yields at most one
// result on average. A byte's table reads are registered, then decided into the queue.
// Reset (synchronous): clears string state, pipeline and queue, threshold back to 161.
// The reverse table is not cleared; entries are undefined until written, no clearing pass.

module utf8_to_codepage_decoder_unit #(
   parameter int RSP_QUEUE_DEPTH = u8cp_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  u8cp_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output u8cp_pkg::rsp_type                rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [u8cp_pkg::THRESHOLD_W-1:0] csr_data
);

   // The reverse table: one write port for table commands, two read ports for lookups.
   logic [7:0] reverse_table_mem [u8cp_pkg::TABLE_DEPTH];

   logic [u8cp_pkg::THRESHOLD_W-1:0] threshold_ff;
   u8cp_pkg::str_state_type          str_ff;
   u8cp_pkg::str_state_type          str_in;
   logic                             s2_valid_ff;
   logic                             s2_valid_in;
   logic [7:0]                       s2_byte_ff;
   logic                             s2_end_ff;
   logic [7:0]                       rd_head0_ff;
   logic [7:0]                       rd_head1_ff;

   u8cp_pkg::decide_type             act_decide;
   u8cp_pkg::decide_type             rej_decide;
   u8cp_pkg::str_state_type          look_state;
   logic [7:0]                       look_p0;
   logic [7:0]                       look_p1;
   logic [7:0]                       look_p2;
   logic [15:0]                      code_head0;
   logic [15:0]                      code_head1;
   logic                             queue_room;
   logic                             s2_fire;
   logic                             req_accept;
   logic                             text_accept;
   logic                             table_write;
   logic [u8cp_pkg::RES_CNT_W-1:0]   push_count;

   // Table address for a sequence starting at a lead byte. Only complete sequences are
   // ever accepted, so the continuation bytes are taken as they stand.
   function automatic logic [15:0] seq_code(input logic [7:0] lead, input logic [7:0] b1,
                                            input logic [7:0] b2);
      logic [7:0]  lead_hi;
      logic [7:0]  lead_lo;
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic [15:0] code;
      lead_hi = lead & u8cp_pkg::LEAD3_DATA;
      lead_lo = lead & u8cp_pkg::CONT_DATA;
      c1      = b1 & u8cp_pkg::CONT_DATA;
      c2      = b2 & u8cp_pkg::CONT_DATA;
      if ((lead & u8cp_pkg::LEAD3_MASK) == u8cp_pkg::LEAD3_MASK) begin
         code = {lead_hi[3:0], c1[5:0], c2[5:0]};
      end else begin
         code = {4'h0, lead_lo[5:0], c1[5:0]};
      end
      return code;
   endfunction

   assign csr_ready = 1'b1;

   // The decide stage fires when it holds a byte and the queue can take three results.
   assign s2_fire     = s2_valid_ff & queue_room;
   assign req_stall   = s2_valid_ff & ~queue_room;
   assign req_accept  = req_valid & ~req_stall;
   assign text_accept = req_accept & (req_payload.command == u8cp_pkg::CMD_TEXT);
   assign table_write = req_accept & (req_payload.command == u8cp_pkg::CMD_TABLE_WRITE);

   // Lookup addresses for a new byte are formed from the state that the byte in the decide
   // stage leaves if it rejects every lookup. If that byte accepts a sequence instead, the
   // window ends up empty, and a lone byte never needs a lookup, so the reads do not matter.
   assign look_state = s2_valid_ff ? rej_decide.next_state : str_ff;

   always_comb begin
      look_p0 = (look_state.cnt != 2'd0) ? look_state.win[0] : req_payload.text_byte;
      look_p1 = (look_state.cnt == 2'd2) ? look_state.win[1] :
                (look_state.cnt == 2'd1) ? req_payload.text_byte : 8'h00;
      look_p2 = (look_state.cnt == 2'd2) ? req_payload.text_byte : 8'h00;
      code_head0 = seq_code(look_p0, look_p1, look_p2);
      code_head1 = seq_code(look_p1, look_p2, 8'h00);
   end

   always_ff @(posedge clock) begin
      if (table_write) begin
         reverse_table_mem[req_payload.table_index] <= req_payload.table_value;
      end
      if (text_accept) begin
         rd_head0_ff <= reverse_table_mem[code_head0];
         rd_head1_ff <= reverse_table_mem[code_head1];
      end
   end

   // Decide stage, once with the real table entries and once with every lookup rejected.
   u8cp_decide u_decide_act (
      .state_in         (str_ff),
      .text_byte        (s2_byte_ff),
      .end_flag         (s2_end_ff),
      .entry_head0      (rd_head0_ff),
      .entry_head1      (rd_head1_ff),
      .accept_threshold (threshold_ff),
      .accept_enable    (1'b1),
      .decide_out       (act_decide)
   );

   u8cp_decide u_decide_rej (
      .state_in         (str_ff),
      .text_byte        (s2_byte_ff),
      .end_flag         (s2_end_ff),
      .entry_head0      (rd_head0_ff),
      .entry_head1      (rd_head1_ff),
      .accept_threshold (threshold_ff),
      .accept_enable    (1'b0),
      .decide_out       (rej_decide)
   );

   always_comb begin
      str_in      = s2_fire ? act_decide.next_state : str_ff;
      s2_valid_in = req_accept ? text_accept : (s2_valid_ff & ~s2_fire);
      push_count  = s2_fire ? act_decide.count : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= u8cp_pkg::THRESHOLD_RESET;
         str_ff       <= u8cp_pkg::STR_STATE_RESET;
         s2_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_data;
         end
         str_ff      <= str_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (text_accept) begin
         s2_byte_ff <= req_payload.text_byte;
         s2_end_ff  <= req_payload.end_flag;
      end
   end

   // Results wait here, so a new byte can be taken while earlier results are not yet taken.
   u8cp_rsp_queue #(
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_items  (act_decide.results),
      .room        (queue_room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
